[hw/rtl/aip_pkg.sv]
// Shared types and codes for the archive index parser.
// No dependencies; imported by the parser stage and the top level.
package aip_pkg;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_LIST_BASE = 4'd1,
        PH_DELIM     = 4'd2,
        PH_LIST_NAME = 4'd3,
        PH_LIST_LEN  = 4'd4,
        PH_COUNT     = 4'd5,
        PH_TAB_BASE  = 4'd6,
        PH_TAB_NAME  = 4'd7,
        PH_COMP      = 4'd8,
        PH_OFF       = 4'd9,
        PH_LEN       = 4'd10,
        PH_ORIG      = 4'd11
    } t_phase;

    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_BYTE  = 2'd1;
    localparam logic [1:0] REQ_EOF   = 2'd2;

    localparam logic [1:0] EV_CHAR  = 2'd0;
    localparam logic [1:0] EV_ENTRY = 2'd1;
    localparam logic [1:0] EV_DONE  = 2'd2;
    localparam logic [1:0] EV_ERR   = 2'd3;

    localparam logic [3:0] ERR_NONE     = 4'd0;
    localparam logic [3:0] ERR_CONFIG   = 4'd1;
    localparam logic [3:0] ERR_BASE     = 4'd2;
    localparam logic [3:0] ERR_TRUNC    = 4'd3;
    localparam logic [3:0] ERR_PAST     = 4'd4;
    localparam logic [3:0] ERR_DELIM    = 4'd5;
    localparam logic [3:0] ERR_BAD_NAME = 4'd6;
    localparam logic [3:0] ERR_EMPTY    = 4'd7;
    localparam logic [3:0] ERR_COUNT    = 4'd8;
    localparam logic [3:0] ERR_RANGE    = 4'd9;
    localparam logic [3:0] ERR_OVERLAP  = 4'd10;

    localparam logic [1:0] FMT_TABLE = 2'd0;
    localparam logic [1:0] FMT_COMP  = 2'd1;
    localparam logic [1:0] FMT_LIST  = 2'd2;
    localparam logic [1:0] FMT_BAD   = 2'd3;

    localparam logic [1:0] CFG_FORMAT   = 2'd0;
    localparam logic [1:0] CFG_OFFSET   = 2'd1;
    localparam logic [1:0] CFG_SIZE     = 2'd2;
    localparam logic [1:0] CFG_MAX_NAME = 2'd3;

    localparam logic [7:0] QUOTE_CHAR   = 8'h22;
    localparam logic [3:0] COMP_MIN_ENT = 4'd14;
    localparam logic [3:0] TAB_MIN_ENT  = 4'd9;
    localparam logic [7:0] UPCASE_DELTA = 8'h20;

endpackage

[hw/rtl/archive_index_parser_core.sv]
// Top level of the archive index parser: configuration registers, parser, result queue.
// Depends on aip_pkg, aip_parse and aip_outq.
//
// Usage: a start transaction (request type 0) begins a parse in the configured
// format, then header bytes (request type 1) are fed one per transaction, and
// an end-of-file transaction (request type 2) ends a parse that is still open.
// Each accepted input transaction yields zero, one or two result transactions:
// upper-cased name characters, entry records, a done record carrying the data
// base, or a single error code after which the parser idles until a new start.
// The last result caused by an input is flagged by last_of_run.
// Results of an accepted input enter the queue at the accepting edge. Throughput
// is one input per cycle while o_stall is low; the parser decodes each byte
// combinationally, and results drain through a four-entry queue at one per
// cycle while i_stall is low. The input side stalls while more than two queue
// entries are held, so a stalled receiver backs up into the input channel once
// three results are queued. Configuration is a plain write port and is meant
// to be written while no parse is running. Reset clears the parse state, empties
// the queue and restores the configuration defaults (max name length 255, others 0).
module archive_index_parser_core import aip_pkg::*; #(
    parameter int ADDR_BITS     = 48,
    parameter int NAME_LEN_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_req_type,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [ADDR_BITS-1:0] i_cfg_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [1:0]           o_event_res,
    output logic [7:0]           o_name_char,
    output logic [ADDR_BITS:0]   o_entry_offset,
    output logic [31:0]          o_entry_length,
    output logic [31:0]          o_original_length,
    output logic                 o_compressed,
    output logic [ADDR_BITS:0]   o_data_base,
    output logic [3:0]           o_error_code,
    output logic                 o_last_of_run
);

    localparam int RW = 2 * ADDR_BITS + 81;

    logic [1:0]               r_format;
    logic [ADDR_BITS-1:0]     r_arch_off, r_arch_size;
    logic [NAME_LEN_BITS-1:0] r_max_name;
    logic                     acc, full;
    logic [1:0]               cnt;
    logic [RW-1:0]            res0, res1;
    logic [RW:0]              q_out;

    // Configuration registers take effect at the next edge.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format    <= FMT_TABLE;
            r_arch_off  <= '0;
            r_arch_size <= '0;
            r_max_name  <= NAME_LEN_BITS'(255);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FORMAT:   r_format    <= i_cfg_data[1:0];
                CFG_OFFSET:   r_arch_off  <= i_cfg_data;
                CFG_SIZE:     r_arch_size <= i_cfg_data;
                CFG_MAX_NAME: r_max_name  <= i_cfg_data[NAME_LEN_BITS-1:0];
            endcase
        end
    end

    assign o_stall = full;
    assign acc     = i_valid && !full;

    aip_parse #(.ADDR_BITS(ADDR_BITS), .NAME_LEN_BITS(NAME_LEN_BITS), .RW(RW)) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (acc),
        .i_req_type  (i_req_type),
        .i_data_byte (i_data_byte),
        .i_format    (r_format),
        .i_arch_off  (r_arch_off),
        .i_arch_size (r_arch_size),
        .i_max_name  (r_max_name),
        .o_cnt       (cnt),
        .o_res0      (res0),
        .o_res1      (res1)
    );

    // The flag for the last result of a run rides in the queue's top bit.
    aip_outq #(.W(RW + 1)) u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (cnt),
        .i_data0    ({cnt == 2'd1, res0}),
        .i_data1    ({1'b1, res1}),
        .i_pop      (o_valid && !i_stall),
        .o_full     (full),
        .o_valid    (o_valid),
        .o_data     (q_out)
    );

    assign {o_last_of_run, o_event_res, o_name_char, o_entry_offset, o_entry_length,
            o_original_length, o_compressed, o_data_base, o_error_code} = q_out;

endmodule

[hw/rtl/aip_parse.sv]
// Parser stage of the archive index parser: parse state and per-byte decode.
// Depends on aip_pkg; produces up to two packed results per transaction.
module aip_parse import aip_pkg::*; #(
    parameter int ADDR_BITS     = 48,
    parameter int NAME_LEN_BITS = 16,
    parameter int RW            = 2 * ADDR_BITS + 81
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_acc,
    input  logic [1:0]               i_req_type,
    input  logic [7:0]               i_data_byte,
    input  logic [1:0]               i_format,
    input  logic [ADDR_BITS-1:0]     i_arch_off,
    input  logic [ADDR_BITS-1:0]     i_arch_size,
    input  logic [NAME_LEN_BITS-1:0] i_max_name,
    output logic [1:0]               o_cnt,
    output logic [RW-1:0]            o_res0,
    output logic [RW-1:0]            o_res1
);

    localparam int PW = ADDR_BITS + 1;

    t_phase                   r_phase, n_phase;
    logic [PW-1:0]            r_pos, n_pos, r_base, n_base, r_run, n_run, r_eoff, n_eoff;
    logic [31:0]              r_shift, n_shift, r_elen, n_elen;
    logic [2:0]               r_bidx, n_bidx;
    logic [15:0]              r_left, n_left;
    logic [NAME_LEN_BITS-1:0] r_ncnt, n_ncnt;
    logic                     r_comp, n_comp;

    function automatic logic [RW-1:0] pack_res(
        input logic [1:0] ev, input logic [7:0] ch, input logic [PW-1:0] off,
        input logic [31:0] len, input logic [31:0] orig, input logic comp,
        input logic [PW-1:0] base, input logic [3:0] err);
        pack_res = {ev, ch, off, len, orig, comp, base, err};
    endfunction

    always_comb begin
        logic [PW-1:0]   pos1, bnew, sz;
        logic [PW:0]     wide_end;
        logic [2:0]      idx1;
        logic [31:0]     le_val, be_val;
        logic [19:0]     prod;
        logic            v_char, v_entry, v_done, v_err, do_lt, do_tt;
        logic [3:0]      ecode;
        logic [7:0]      ch;
        logic [PW-1:0]   e_off;
        logic [31:0]     e_len, e_orig;
        logic            e_comp;
        logic [RW-1:0]   prim, sec;

        n_phase = r_phase; n_pos = r_pos; n_base = r_base; n_run = r_run;
        n_eoff = r_eoff; n_shift = r_shift; n_elen = r_elen; n_bidx = r_bidx;
        n_left = r_left; n_ncnt = r_ncnt; n_comp = r_comp;
        v_char = 1'b0; v_entry = 1'b0; v_done = 1'b0; v_err = 1'b0;
        do_lt = 1'b0; do_tt = 1'b0; ecode = ERR_NONE;
        e_off = '0; e_len = '0; e_orig = '0; e_comp = 1'b0;
        ch = (i_data_byte >= 8'h61 && i_data_byte <= 8'h7a)
             ? i_data_byte - UPCASE_DELTA : i_data_byte;
        sz = {1'b0, i_arch_size};
        pos1 = r_pos + PW'(1);
        idx1 = r_bidx + 3'd1;
        le_val = r_shift | ({24'd0, i_data_byte} << {r_bidx[1:0], 3'b000});
        be_val = {r_shift[23:0], i_data_byte};
        bnew = {1'b0, i_arch_off};
        wide_end = '0;
        prod = r_left * ((i_format == FMT_COMP) ? COMP_MIN_ENT : TAB_MIN_ENT);

        if (i_acc && i_req_type == REQ_START) begin
            n_phase = PH_IDLE; n_base = '0; n_shift = '0; n_bidx = '0; n_left = '0;
            n_ncnt = '0; n_eoff = '0; n_elen = '0; n_comp = 1'b0; n_run = '0;
            n_pos = {1'b0, i_arch_off};
            if (i_max_name == '0 || i_format == FMT_BAD) begin
                v_err = 1'b1; ecode = ERR_CONFIG;
            end else if (i_arch_off > i_arch_size) begin
                v_err = 1'b1; ecode = ERR_BASE;
            end else begin
                n_phase = (i_format == FMT_LIST) ? PH_LIST_BASE : PH_COUNT;
            end
        end else if (i_acc && i_req_type == REQ_EOF && r_phase != PH_IDLE) begin
            v_err = 1'b1; ecode = ERR_TRUNC;
        end else if (i_acc && i_req_type == REQ_BYTE && r_phase != PH_IDLE) begin
            n_pos = pos1;
            unique case (r_phase)
                PH_LIST_BASE: begin
                    if (idx1 < 3'd4) begin
                        n_shift = le_val; n_bidx = idx1;
                    end else begin
                        n_shift = '0; n_bidx = '0;
                        bnew = {1'b0, i_arch_off} + PW'(le_val);
                        n_base = bnew;
                        if (bnew > sz) begin
                            v_err = 1'b1; ecode = ERR_BASE;
                        end else begin
                            n_run = bnew; do_lt = 1'b1;
                        end
                    end
                end
                PH_DELIM: begin
                    if (i_data_byte != QUOTE_CHAR) begin
                        if ({1'b0, r_pos} + (PW+1)'(1) == {1'b0, r_base}) v_done = 1'b1;
                        else begin
                            v_err = 1'b1; ecode = ERR_DELIM;
                        end
                    end else begin
                        n_ncnt = '0;
                        if (pos1 >= r_base) begin
                            v_err = 1'b1; ecode = ERR_PAST;
                        end else n_phase = PH_LIST_NAME;
                    end
                end
                PH_LIST_NAME: begin
                    if (i_data_byte == QUOTE_CHAR) begin
                        if (r_ncnt == '0) begin
                            v_err = 1'b1; ecode = ERR_EMPTY;
                        end else if ({1'b0, pos1} + (PW+1)'(4) > {1'b0, r_base}) begin
                            v_err = 1'b1; ecode = ERR_TRUNC;
                        end else n_phase = PH_LIST_LEN;
                    end else if (i_data_byte == 8'd0 || r_ncnt >= i_max_name) begin
                        v_err = 1'b1; ecode = ERR_BAD_NAME;
                    end else begin
                        v_char = 1'b1; n_ncnt = r_ncnt + NAME_LEN_BITS'(1);
                        if (pos1 >= r_base) begin
                            v_err = 1'b1; ecode = ERR_PAST;
                        end
                    end
                end
                PH_LIST_LEN: begin
                    if (idx1 < 3'd4) begin
                        n_shift = le_val; n_bidx = idx1;
                    end else begin
                        n_shift = '0; n_bidx = '0; n_elen = le_val;
                        wide_end = {1'b0, r_run} + (PW+1)'(le_val);
                        if (wide_end > {1'b0, sz}) begin
                            v_err = 1'b1; ecode = ERR_RANGE;
                        end else begin
                            v_entry = 1'b1; e_off = r_run; e_len = le_val;
                            e_orig = le_val; n_run = wide_end[PW-1:0]; do_lt = 1'b1;
                        end
                    end
                end
                PH_COUNT: begin
                    if (idx1 < 3'd2) begin
                        n_shift = be_val; n_bidx = idx1;
                    end else begin
                        n_shift = '0; n_bidx = '0; n_left = be_val[15:0];
                        n_phase = PH_TAB_BASE;
                    end
                end
                PH_TAB_BASE: begin
                    if (idx1 < 3'd4) begin
                        n_shift = be_val; n_bidx = idx1;
                    end else begin
                        n_shift = '0; n_bidx = '0;
                        bnew = {1'b0, i_arch_off} + PW'(be_val);
                        n_base = bnew;
                        if (bnew > sz) begin
                            v_err = 1'b1; ecode = ERR_BASE;
                        end else if (ADDR_BITS'(prod) > i_arch_size) begin
                            v_err = 1'b1; ecode = ERR_COUNT;
                        end else do_tt = 1'b1;
                    end
                end
                PH_TAB_NAME: begin
                    if (i_data_byte == 8'd0) begin
                        if (r_ncnt == '0) begin
                            v_err = 1'b1; ecode = ERR_EMPTY;
                        end else begin
                            n_comp = 1'b0;
                            n_phase = (i_format == FMT_COMP) ? PH_COMP : PH_OFF;
                        end
                    end else if (r_ncnt >= i_max_name) begin
                        v_err = 1'b1; ecode = ERR_BAD_NAME;
                    end else begin
                        v_char = 1'b1; n_ncnt = r_ncnt + NAME_LEN_BITS'(1);
                        if (pos1 >= r_base) begin
                            v_err = 1'b1; ecode = ERR_PAST;
                        end
                    end
                end
                PH_COMP: begin
                    n_comp = (i_data_byte != 8'd0);
                    n_phase = PH_OFF;
                end
                PH_OFF: begin
                    if (idx1 < 3'd4) begin
                        n_shift = be_val; n_bidx = idx1;
                    end else begin
                        // The entry start is formed here; the base is fixed by now.
                        n_shift = '0; n_bidx = '0;
                        n_eoff = r_base + PW'(be_val);
                        n_phase = PH_LEN;
                    end
                end
                PH_LEN, PH_ORIG: begin
                    if (idx1 < 3'd4) begin
                        n_shift = be_val; n_bidx = idx1;
                    end else begin
                        n_shift = '0; n_bidx = '0;
                        if (r_phase == PH_LEN) n_elen = be_val;
                        if (r_phase == PH_LEN && i_format == FMT_COMP) begin
                            n_phase = PH_ORIG;
                        end else begin
                            wide_end = {1'b0, r_eoff} + (PW+1)'(n_elen);
                            if (wide_end > {1'b0, sz}) begin
                                v_err = 1'b1; ecode = ERR_RANGE;
                            end else begin
                                v_entry = 1'b1; e_off = r_eoff; e_len = n_elen;
                                e_orig = be_val; e_comp = r_comp;
                                n_left = r_left - 16'd1; do_tt = 1'b1;
                            end
                        end
                    end
                end
                default: n_phase = PH_IDLE;
            endcase

            if (do_lt) begin
                if (pos1 > n_base) begin
                    v_err = 1'b1; ecode = ERR_PAST;
                end else if (pos1 == n_base) v_done = 1'b1;
                else n_phase = PH_DELIM;
            end
            if (do_tt) begin
                if (n_left == 16'd0) begin
                    if (pos1 > n_base) begin
                        v_err = 1'b1; ecode = ERR_OVERLAP;
                    end else v_done = 1'b1;
                end else begin
                    n_ncnt = '0;
                    if (pos1 >= n_base) begin
                        v_err = 1'b1; ecode = ERR_PAST;
                    end else n_phase = PH_TAB_NAME;
                end
            end
        end
        if (v_err || v_done) n_phase = PH_IDLE;

        prim = v_char ? pack_res(EV_CHAR, ch, '0, '0, '0, 1'b0, '0, ERR_NONE)
                      : pack_res(EV_ENTRY, 8'd0, e_off, e_len, e_orig, e_comp, '0, ERR_NONE);
        sec  = v_err ? pack_res(EV_ERR, 8'd0, '0, '0, '0, 1'b0, '0, ecode)
                     : pack_res(EV_DONE, 8'd0, '0, '0, '0, 1'b0, n_base, ERR_NONE);
        if (v_char || v_entry) begin
            o_res0 = prim; o_res1 = sec;
            o_cnt  = (v_err || v_done) ? 2'd2 : 2'd1;
        end else begin
            o_res0 = sec; o_res1 = sec;
            o_cnt  = (v_err || v_done) ? 2'd1 : 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_pos <= '0; r_base <= '0; r_run <= '0; r_eoff <= '0;
            r_shift <= '0; r_elen <= '0; r_bidx <= '0; r_left <= '0; r_ncnt <= '0;
            r_comp <= 1'b0;
        end else begin
            r_phase <= n_phase; r_pos <= n_pos; r_base <= n_base; r_run <= n_run;
            r_eoff <= n_eoff; r_shift <= n_shift; r_elen <= n_elen; r_bidx <= n_bidx;
            r_left <= n_left; r_ncnt <= n_ncnt; r_comp <= n_comp;
        end
    end

`ifndef ASSERT_OFF
    a_bidx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bidx < 3'd4) else $error("field byte index out of range");
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_acc && i_req_type == REQ_START) |=> r_bidx == 3'd0 && r_shift == 32'd0)
        else $error("start left a partial field");
    a_err_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cnt != 2'd0 && o_res1[RW-1 -: 2] == EV_ERR && o_cnt == 2'd2) |=>
        r_phase == PH_IDLE) else $error("parser kept running after an error");
`endif

endmodule

[hw/rtl/aip_outq.sv]
// Result queue of the archive index parser: four entries, two pushes, one pop.
// No package dependencies; instantiated by the top level.
module aip_outq #(
    parameter int W = 178
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [1:0]   i_push_cnt,
    input  logic [W-1:0] i_data0,
    input  logic [W-1:0] i_data1,
    input  logic         i_pop,
    output logic         o_full,
    output logic         o_valid,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_mem [4];
    logic [1:0]   r_rd, r_wr;
    logic [2:0]   r_count;

    assign o_valid = (r_count != 3'd0);
    assign o_full  = (r_count > 3'd2);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) r_mem[r_wr] <= i_data0;
        if (i_push_cnt == 2'd2) r_mem[r_wr + 2'd1] <= i_data1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= '0; r_wr <= '0; r_count <= '0;
        end else begin
            r_wr    <= r_wr + i_push_cnt;
            r_rd    <= r_rd + {1'b0, i_pop};
            r_count <= r_count + {1'b0, i_push_cnt} - {2'b0, i_pop};
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'd4) else $error("result queue overflow");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_cnt != 2'd0) |-> r_count <= 3'd2) else $error("push into full queue");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != 3'd0) else $error("pop from empty queue");
`endif

endmodule

[verif/archive_index_parser_core_tb.sv]
// Self-checking testbench for archive_index_parser_core: random archive headers in all
// three formats, checked against a built-in parser model. Depends on aip_pkg and the RTL.
module archive_index_parser_core_tb;
    import aip_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int AB = 48;
    localparam logic [47:0] ADDR_MAX = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [1:0] req;
        logic [7:0] data;
    } t_header_req;

    typedef struct packed {
        logic [1:0]  ev;
        logic [7:0]  ch;
        logic [48:0] off;
        logic [31:0] len;
        logic [31:0] orig;
        logic        comp;
        logic [48:0] base;
        logic [3:0]  err;
        logic        last;
    } t_parse_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_req_type;
    logic [7:0]  i_data_byte;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [47:0] i_cfg_data;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_event_res;
    logic [7:0]  o_name_char;
    logic [48:0] o_entry_offset;
    logic [31:0] o_entry_length;
    logic [31:0] o_original_length;
    logic        o_compressed;
    logic [48:0] o_data_base;
    logic [3:0]  o_error_code;
    logic        o_last_of_run;

    archive_index_parser_core #(.ADDR_BITS(48), .NAME_LEN_BITS(16)) u_dut (.*);

    // Configuration copy kept by the model.
    logic [1:0]  m_format;
    logic [47:0] m_arch_off;
    logic [47:0] m_arch_size;
    logic [15:0] m_max_name;

    // Parser state of the model.
    t_phase      ph;
    logic [48:0] pos;
    logic [48:0] base_off;
    logic [31:0] shreg;
    logic [2:0]  shcnt;
    logic [15:0] ents_left;
    logic [15:0] name_cnt;
    logic [31:0] ent_rel;
    logic [31:0] ent_len;
    logic        comp_flag;
    logic [48:0] run_off;

    t_parse_result step_res[$];
    t_parse_result expected_results[$];
    t_header_req   pending_requests[$];

    int  errors = 0;
    int  n_pushed = 0;
    int  push_cap = 1_000_000;
    int  n_accepted = 0;
    int  n_results = 0;
    int  n_err_events = 0;
    int  n_entries = 0;
    bit  quiet = 0;
    bit  long_hold_req = 0;
    bit  taken = 0;
    int  send_gap = 0;
    int  recv_hold = 0;

    //------------------------------------------------------------------
    // Model of the parser. Results of one transaction gather in step_res.
    //------------------------------------------------------------------
    task automatic emit(input logic [1:0] ev, input logic [7:0] ch, input logic [48:0] off,
                        input logic [31:0] len, input logic [31:0] orig, input logic comp,
                        input logic [48:0] base, input logic [3:0] err);
        t_parse_result r;
        if (step_res.size() < 2) begin
            r = '{ev, ch, off, len, orig, comp, base, err, 1'b0};
            step_res.insert(step_res.size(), r);
        end
    endtask

    task automatic abort_parse(input logic [3:0] code);
        emit(EV_ERR, 0, 0, 0, 0, 0, 0, code);
        ph = PH_IDLE;
    endtask

    task automatic close_parse();
        emit(EV_DONE, 0, 0, 0, 0, 0, base_off, ERR_NONE);
        ph = PH_IDLE;
    endtask

    // Collects one byte of a multi-byte field; returns one when all are in.
    function automatic bit gather(input logic [7:0] b, input int nbytes, input bit little);
        if (little)
            shreg = shreg | (32'(b) << (8 * (shcnt & 3'd3)));
        else
            shreg = {shreg[23:0], b};
        shcnt = shcnt + 3'd1;
        return int'(shcnt) >= nbytes;
    endfunction

    function automatic logic [31:0] field_value();
        logic [31:0] v;
        v = shreg;
        shreg = 0;
        shcnt = 0;
        return v;
    endfunction

    task automatic emit_upper(input logic [7:0] b);
        logic [7:0] c;
        c = b;
        if (c >= "a" && c <= "z")
            c = c - 8'h20;
        emit(EV_CHAR, c, 0, 0, 0, 0, 0, ERR_NONE);
        name_cnt = name_cnt + 16'd1;
    endtask

    task automatic list_next();
        if (pos > base_off)
            abort_parse(ERR_PAST);
        else if (pos == base_off)
            close_parse();
        else
            ph = PH_DELIM;
    endtask

    task automatic table_next();
        if (ents_left == 0) begin
            if (pos > base_off)
                abort_parse(ERR_OVERLAP);
            else
                close_parse();
        end else begin
            name_cnt = 0;
            if (pos >= base_off)
                abort_parse(ERR_PAST);
            else
                ph = PH_TAB_NAME;
        end
    endtask

    task automatic table_record(input logic [31:0] orig);
        logic [63:0] off;
        logic [63:0] fin;
        off = 64'(base_off) + 64'(ent_rel);
        fin = off + 64'(ent_len);
        if (fin > 64'(m_arch_size)) begin
            abort_parse(ERR_RANGE);
        end else begin
            emit(EV_ENTRY, 0, off[48:0], ent_len, orig, comp_flag, 0, ERR_NONE);
            ents_left = ents_left - 16'd1;
            table_next();
        end
    endtask

    task automatic parse_byte(input logic [7:0] b);
        logic [63:0] here;
        logic [63:0] fin;
        logic [63:0] need;
        here = 64'(pos);
        pos = pos + 49'd1;
        case (ph)
            PH_LIST_BASE: begin
                if (gather(b, 4, 1)) begin
                    base_off = 49'(m_arch_off) + 49'(field_value());
                    if (base_off > 49'(m_arch_size)) begin
                        abort_parse(ERR_BASE);
                    end else begin
                        run_off = base_off;
                        list_next();
                    end
                end
            end
            PH_DELIM: begin
                if (b != QUOTE_CHAR) begin
                    if (here + 64'd1 == 64'(base_off))
                        close_parse();
                    else
                        abort_parse(ERR_DELIM);
                end else begin
                    name_cnt = 0;
                    if (pos >= base_off)
                        abort_parse(ERR_PAST);
                    else
                        ph = PH_LIST_NAME;
                end
            end
            PH_LIST_NAME: begin
                if (b == QUOTE_CHAR) begin
                    if (name_cnt == 0)
                        abort_parse(ERR_EMPTY);
                    else if (pos > base_off || base_off - pos < 49'd4)
                        abort_parse(ERR_TRUNC);
                    else
                        ph = PH_LIST_LEN;
                end else if (b == 8'd0 || name_cnt >= m_max_name) begin
                    abort_parse(ERR_BAD_NAME);
                end else begin
                    emit_upper(b);
                    if (pos >= base_off)
                        abort_parse(ERR_PAST);
                end
            end
            PH_LIST_LEN: begin
                if (gather(b, 4, 1)) begin
                    ent_len = field_value();
                    fin = 64'(run_off) + 64'(ent_len);
                    if (fin > 64'(m_arch_size)) begin
                        abort_parse(ERR_RANGE);
                    end else begin
                        emit(EV_ENTRY, 0, run_off, ent_len, ent_len, 0, 0, ERR_NONE);
                        run_off = fin[48:0];
                        list_next();
                    end
                end
            end
            PH_COUNT: begin
                if (gather(b, 2, 0)) begin
                    ents_left = 16'(field_value());
                    ph = PH_TAB_BASE;
                end
            end
            PH_TAB_BASE: begin
                if (gather(b, 4, 0)) begin
                    base_off = 49'(m_arch_off) + 49'(field_value());
                    need = 64'(ents_left) * ((m_format == FMT_COMP) ? 64'(COMP_MIN_ENT)
                                                                    : 64'(TAB_MIN_ENT));
                    if (base_off > 49'(m_arch_size))
                        abort_parse(ERR_BASE);
                    else if (need > 64'(m_arch_size))
                        abort_parse(ERR_COUNT);
                    else
                        table_next();
                end
            end
            PH_TAB_NAME: begin
                if (b == 8'd0) begin
                    if (name_cnt == 0) begin
                        abort_parse(ERR_EMPTY);
                    end else begin
                        comp_flag = 0;
                        ph = (m_format == FMT_COMP) ? PH_COMP : PH_OFF;
                    end
                end else if (name_cnt >= m_max_name) begin
                    abort_parse(ERR_BAD_NAME);
                end else begin
                    emit_upper(b);
                    if (pos >= base_off)
                        abort_parse(ERR_PAST);
                end
            end
            PH_COMP: begin
                comp_flag = (b != 0);
                ph = PH_OFF;
            end
            PH_OFF: begin
                if (gather(b, 4, 0)) begin
                    ent_rel = field_value();
                    ph = PH_LEN;
                end
            end
            PH_LEN: begin
                if (gather(b, 4, 0)) begin
                    ent_len = field_value();
                    if (m_format == FMT_COMP)
                        ph = PH_ORIG;
                    else
                        table_record(ent_len);
                end
            end
            PH_ORIG: begin
                if (gather(b, 4, 0))
                    table_record(field_value());
            end
            default: ph = PH_IDLE;
        endcase
    endtask

    task automatic clear_parse_state();
        ph = PH_IDLE;
        pos = 0;
        base_off = 0;
        shreg = 0;
        shcnt = 0;
        ents_left = 0;
        name_cnt = 0;
        ent_rel = 0;
        ent_len = 0;
        comp_flag = 0;
        run_off = 0;
    endtask

    // Predicts the results of one accepted input transaction.
    task automatic predict_parse(input t_header_req t);
        step_res.delete();
        case (t.req)
            REQ_START: begin
                clear_parse_state();
                pos = 49'(m_arch_off);
                if (m_max_name == 0 || m_format == FMT_BAD)
                    abort_parse(ERR_CONFIG);
                else if (m_arch_off > m_arch_size)
                    abort_parse(ERR_BASE);
                else
                    ph = (m_format == FMT_LIST) ? PH_LIST_BASE : PH_COUNT;
            end
            REQ_BYTE: if (ph != PH_IDLE) parse_byte(t.data);
            REQ_EOF:  if (ph != PH_IDLE) abort_parse(ERR_TRUNC);
            default: ;
        endcase
        if (step_res.size() > 0)
            step_res[step_res.size() - 1].last = 1'b1;
        foreach (step_res[k])
            expected_results.insert(expected_results.size(), step_res[k]);
    endtask

    //------------------------------------------------------------------
    // Clock, reset and timeout.
    //------------------------------------------------------------------
    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // The timeout lies well beyond the slowest correct run.
    initial begin
        #4ms;
        $display("timeout with %0d results still expected", expected_results.size());
        $display("status: fail");
        $finish;
    end

    //------------------------------------------------------------------
    // Monitor: at each rising edge, check the result transaction that was
    // taken and feed the accepted input transaction to the model.
    //------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_parse_result want;
        t_parse_result got;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_event_res, o_name_char, o_entry_offset, o_entry_length,
                    o_original_length, o_compressed, o_data_base, o_error_code, o_last_of_run};
            n_results++;
            if (got.ev == EV_ERR) n_err_events++;
            if (got.ev == EV_ENTRY) n_entries++;
            if (expected_results.size() == 0) begin
                errors++;
                $display("%t: unexpected result transaction %p", $time, got);
            end else begin
                want = expected_results.pop_front();
                if (got.ev != want.ev) begin
                    errors++;
                    $display("%t: event expected %0d actual %0d", $time, want.ev, got.ev);
                end
                if (got.ch != want.ch) begin
                    errors++;
                    $display("%t: name_char expected %h actual %h", $time, want.ch, got.ch);
                end
                if (got.off != want.off) begin
                    errors++;
                    $display("%t: entry_offset expected %h actual %h", $time, want.off,
                             got.off);
                end
                if (got.len != want.len) begin
                    errors++;
                    $display("%t: entry_length expected %h actual %h", $time, want.len,
                             got.len);
                end
                if (got.orig != want.orig) begin
                    errors++;
                    $display("%t: original_length expected %h actual %h", $time, want.orig,
                             got.orig);
                end
                if (got.comp != want.comp) begin
                    errors++;
                    $display("%t: compressed expected %b actual %b", $time, want.comp,
                             got.comp);
                end
                if (got.base != want.base) begin
                    errors++;
                    $display("%t: data_base expected %h actual %h", $time, want.base,
                             got.base);
                end
                if (got.err != want.err) begin
                    errors++;
                    $display("%t: error_code expected %0d actual %0d", $time, want.err,
                             got.err);
                end
                if (got.last != want.last) begin
                    errors++;
                    $display("%t: last_of_run expected %b actual %b", $time, want.last,
                             got.last);
                end
            end
        end
        if (i_rst_n && i_valid && !o_stall) begin
            predict_parse('{i_req_type, i_data_byte});
            n_accepted++;
            taken = 1;
        end
    end

    //------------------------------------------------------------------
    // Driver: presents pending transactions at the falling edge, with
    // random gaps. A presented transaction holds until it is taken.
    //------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_header_req nxt;
        logic        v;
        v = i_valid;
        nxt = '{i_req_type, i_data_byte};
        if (!i_valid || taken) begin
            v = 0;
            if (send_gap > 0) begin
                send_gap--;
            end else if (pending_requests.size() > 0) begin
                if (!quiet && $urandom_range(0, 9) == 0) begin
                    send_gap = $urandom_range(1, 12) - 1;
                end else begin
                    nxt = pending_requests.pop_front();
                    v = 1;
                end
            end
        end
        taken = 0;
        i_valid <= v;
        i_req_type <= nxt.req;
        i_data_byte <= nxt.data;
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    always @(negedge i_clk) begin
        logic s;
        s = 0;
        if (recv_hold > 0) begin
            recv_hold--;
            s = 1;
        end else if (long_hold_req) begin
            long_hold_req = 0;
            recv_hold = 150;
            s = 1;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            recv_hold = $urandom_range(1, 12) - 1;
            s = 1;
        end
        i_stall <= s;
    end

    //------------------------------------------------------------------
    // Stimulus helpers.
    //------------------------------------------------------------------
    // Transactions beyond the current budget are dropped, which may cut the
    // last header of a phase short; the next start begins a fresh parse.
    task automatic push_req(input logic [1:0] r, input logic [7:0] b);
        t_header_req t;
        t = '{r, b};
        if (n_pushed < push_cap) begin
            pending_requests.insert(pending_requests.size(), t);
            n_pushed++;
        end
    endtask

    // Waits for every transaction to be taken and every result to arrive,
    // then lets the pipeline settle before the configuration changes.
    task automatic drain();
        wait (n_accepted == n_pushed && expected_results.size() == 0);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [47:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_FORMAT:   m_format = val[1:0];
            CFG_OFFSET:   m_arch_off = val;
            CFG_SIZE:     m_arch_size = val;
            CFG_MAX_NAME: m_max_name = val[15:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic configure(input logic [1:0] fmt, input logic [47:0] aoff,
                             input logic [47:0] asize, input logic [15:0] mname);
        drain();
        write_reg(CFG_FORMAT, 48'(fmt));
        write_reg(CFG_OFFSET, aoff);
        write_reg(CFG_SIZE, asize);
        write_reg(CFG_MAX_NAME, 48'(mname));
    endtask

    function automatic logic [7:0] name_byte(input bit list_fmt);
        logic [7:0] b;
        do begin
            if ($urandom_range(0, 1))
                b = 8'($urandom_range(8'h61, 8'h7A));
            else
                b = 8'($urandom_range(1, 255));
        end while (list_fmt && b == QUOTE_CHAR);
        return b;
    endfunction

    function automatic int name_len();
        int lim;
        lim = (m_max_name == 0) ? 1 : ((m_max_name > 6) ? 6 : int'(m_max_name));
        if ($urandom_range(0, 15) == 0)
            return int'(m_max_name) + 1 > 300 ? 300 : int'(m_max_name) + 1;
        if ($urandom_range(0, 7) == 0)
            return (m_max_name > 40) ? 40 : int'(m_max_name);
        return $urandom_range(1, lim);
    endfunction

    function automatic logic [31:0] rand_len();
        if ($urandom_range(0, 19) == 0)
            return 32'hFFFF_FFFF;
        return $urandom_range(0, 4000);
    endfunction

    // Builds one header in the configured format, possibly damages it, and
    // queues a start transaction followed by its bytes.
    task automatic queue_archive();
        logic [7:0]  body[$];
        logic [7:0]  hdr[$];
        logic [31:0] rel;
        logic [31:0] v;
        int          n_ent;
        int          nl;
        int          k;
        n_ent = $urandom_range(0, 4);
        if (m_format == FMT_LIST) begin
            for (int e = 0; e < n_ent; e++) begin
                body.insert(body.size(), QUOTE_CHAR);
                nl = name_len();
                for (int c = 0; c < nl; c++)
                    body.insert(body.size(), name_byte(1));
                body.insert(body.size(), QUOTE_CHAR);
                v = rand_len();
                for (int c = 0; c < 4; c++)
                    body.insert(body.size(), v[8*c +: 8]);
            end
            rel = 32'(4 + body.size());
            for (int c = 0; c < 4; c++)
                hdr.insert(hdr.size(), rel[8*c +: 8]);
        end else begin
            for (int e = 0; e < n_ent; e++) begin
                nl = name_len();
                for (int c = 0; c < nl; c++)
                    body.insert(body.size(), name_byte(0));
                body.insert(body.size(), 8'd0);
                if (m_format == FMT_COMP)
                    body.insert(body.size(),
                                $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(1, 255)));
                v = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 20000);
                for (int c = 3; c >= 0; c--)
                    body.insert(body.size(), v[8*c +: 8]);
                v = rand_len();
                for (int c = 3; c >= 0; c--)
                    body.insert(body.size(), v[8*c +: 8]);
                if (m_format == FMT_COMP) begin
                    v = $urandom;
                    for (int c = 3; c >= 0; c--)
                        body.insert(body.size(), v[8*c +: 8]);
                end
            end
            rel = 32'(6 + body.size());
            hdr.insert(hdr.size(), 8'(n_ent >> 8));
            hdr.insert(hdr.size(), 8'(n_ent));
            for (int c = 3; c >= 0; c--)
                hdr.insert(hdr.size(), rel[8*c +: 8]);
        end
        foreach (body[c])
            hdr.insert(hdr.size(), body[c]);
        // Damage about a third of the headers in assorted ways.
        case ($urandom_range(0, 11))
            0, 1: begin
                k = $urandom_range(0, hdr.size() - 1);
                hdr[k] = 8'($urandom);
            end
            2: begin
                k = $urandom_range(0, hdr.size() - 1);
                hdr[k] = QUOTE_CHAR;
            end
            3: begin
                k = $urandom_range(0, hdr.size());
                while (hdr.size() > k) void'(hdr.pop_back());
                hdr.insert(hdr.size(), 8'hxx);
            end
            default: ;
        endcase
        push_req(REQ_START, 8'($urandom));
        foreach (hdr[c]) begin
            if ($isunknown(hdr[c]))
                push_req(REQ_EOF, 8'($urandom));
            else
                push_req(REQ_BYTE, hdr[c]);
        end
        // Occasional trailing noise: end-of-file requests, stray bytes, unused request type.
        case ($urandom_range(0, 9))
            0: push_req(REQ_EOF, 8'($urandom));
            1: push_req(2'd3, 8'($urandom));
            2: push_req(REQ_BYTE, 8'($urandom));
            default: ;
        endcase
    endtask

    task automatic run_phase(input int n_items);
        int target;
        target = n_pushed + n_items;
        push_cap = target;
        while (n_pushed < target) begin
            queue_archive();
            wait (pending_requests.size() < 40);
        end
    endtask

    //------------------------------------------------------------------
    // Test sequence.
    //------------------------------------------------------------------
    initial begin
        i_rst_n = 0;
        i_valid = 0;
        i_req_type = REQ_START;
        i_data_byte = 0;
        i_cfg_we = 0;
        i_cfg_index = CFG_FORMAT;
        i_cfg_data = 0;
        i_stall = 0;
        m_format = FMT_TABLE;
        m_arch_off = 0;
        m_arch_size = 0;
        m_max_name = 16'd255;
        clear_parse_state();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // Directed: idle requests are ignored, an empty table under the reset
        // configuration fails the base check, end of file truncates, a second start restarts.
        push_req(REQ_EOF, 8'h00);
        push_req(REQ_BYTE, 8'hFF);
        push_req(2'd3, 8'hA5);
        push_req(REQ_START, 8'h00);
        push_req(REQ_BYTE, 8'h00);
        push_req(REQ_BYTE, 8'h00);
        push_req(REQ_BYTE, 8'h00);
        push_req(REQ_BYTE, 8'h00);
        push_req(REQ_BYTE, 8'h00);
        push_req(REQ_BYTE, 8'h06);
        push_req(REQ_START, 8'hFF);
        push_req(REQ_EOF, 8'hFF);
        push_req(REQ_START, 8'h00);
        push_req(REQ_BYTE, 8'h00);
        push_req(REQ_START, 8'h00);
        push_req(REQ_BYTE, 8'hFF);
        push_req(REQ_BYTE, 8'hFF);
        push_req(REQ_BYTE, 8'h00);
        push_req(REQ_BYTE, 8'h00);
        push_req(REQ_BYTE, 8'h00);
        push_req(REQ_BYTE, 8'h00);

        // Plain table with roomy limits, then a long receiver hold-off while the
        // sender keeps offering so that the result queue backs up.
        configure(FMT_TABLE, 48'd0, 48'd1_000_000, 16'd255);
        run_phase(150);
        long_hold_req = 1;
        run_phase(150);
        // Compressed table at the top of the address range with tiny names.
        configure(FMT_COMP, 48'h7FFF_FFFF_0000, ADDR_MAX, 16'd3);
        run_phase(300);
        // Quoted list with the widest name limit.
        configure(FMT_LIST, 48'h1_2345_6789, 48'h2_0000_0000, 16'hFFFF);
        run_phase(300);
        // Error-heavy settings: bad format, zero name limit, offset past the end.
        configure(FMT_BAD, 48'd0, 48'd100, 16'd255);
        run_phase(40);
        configure(FMT_TABLE, 48'd0, 48'd100, 16'd0);
        run_phase(40);
        configure(FMT_LIST, ADDR_MAX, ADDR_MAX, 16'd1);
        run_phase(40);
        configure(FMT_COMP, 48'd10, 48'd5, 16'd8);
        run_phase(40);
        // Small archives so entries and counts run past the end.
        configure(FMT_LIST, 48'd0, 48'd60, 16'd4);
        run_phase(200);
        configure(FMT_TABLE, 48'd0, 48'd0, 16'd255);
        run_phase(60);
        configure(FMT_COMP, 48'd0, 48'd120, 16'd255);
        run_phase(200);
        // Final stretch without idling on either side.
        configure(FMT_LIST, 48'd3, 48'd900_000, 16'd255);
        quiet = 1;
        run_phase(150);
        configure(FMT_COMP, 48'd0, 48'd2_000_000, 16'd255);
        run_phase(150);

        drain();
        repeat (10) @(negedge i_clk);
        $display("covered %0d input transactions and %0d results (%0d entries, %0d errors)",
                 n_accepted, n_results, n_entries, n_err_events);
        $display("across all three formats, bad configurations and damaged headers");
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", errors);
            $display("status: fail");
        end
        $finish;
    end
endmodule
